FILE: rtl/odz_pkg.sv
// ----------------------------------------------------------------------------
// odz_pkg
// Shared types and constants of the ordered-dither zoom replicator.
// ----------------------------------------------------------------------------
package odz_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_MATRIX_SIDE  = 16;
    localparam int DEF_MAX_ZOOM     = 32;
    localparam int DEF_MAX_ROW_BITS = 4096;

    // Threshold matrix store.
    localparam int MAT_DEPTH = 256;
    localparam int MAT_AW    = 8;
    localparam int THR_W     = 9;

    // Field widths.
    localparam int LEVEL_W  = 8;
    localparam int POS_W    = 13;
    localparam int ROW_W    = 12;
    localparam int BOFF_W   = 9;
    localparam int HEIGHT_W = 13;
    localparam int ROW_LIMIT = 4096;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_ZOOM          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_X_REPS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_Y_REPS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_START       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT        = 3'd7;

    // Input word kinds.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // One result word.
    typedef struct packed {
        logic [7:0]        set_bits;
        logic [ROW_W-1:0]  row_index;
        logic [BOFF_W-1:0] byte_offset;
        logic              last_in_row;
        logic              advance_source_row;
        logic              last_of_item;
    } odz_result_t;

endpackage

FILE: rtl/ordered_dither_zoom_replicate_top.sv
// ----------------------------------------------------------------------------
// ordered_dither_zoom_replicate_top
// Replicates source levels along a row and dithers them against a 16x16
// threshold matrix, packing the set bits into bitmap bytes.
// ----------------------------------------------------------------------------
// A threshold load word is written straight into the matrix store. A sample
// word is worked through by the single compare unit, which handles one output
// bit at a time, over the output bits it covers (up to the zoom factor), or
// closes the row with one word when the row is empty. The registered read
// port of the threshold memory needs a read state before each new matrix
// column, and any stall on the result side holds the sequence. Result words
// sit in an output register, so the next input word is taken while one waits.
// ----------------------------------------------------------------------------
module ordered_dither_zoom_replicate_top
    import odz_pkg::*;
#(
    parameter int MATRIX_SIDE  = DEF_MATRIX_SIDE,
    parameter int MAX_ZOOM     = DEF_MAX_ZOOM,
    parameter int MAX_ROW_BITS = DEF_MAX_ROW_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,  // entry_index, entry_value, level, zero pad
    input  logic                  s_tuser,  // action
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,  // set_bits, row_index, byte_offset, zero pad
    output logic                  m_tlast,  // last_in_row
    output logic [1:0]            m_tuser   // advance_source_row, last_of_item
);

    localparam int REP_W   = $clog2(MAX_ZOOM + 2);
    localparam int MS_W    = $clog2(MATRIX_SIDE);
    localparam int LW_MIN  = $clog2(MAX_ROW_BITS) + 2;
    localparam int LW      = (LW_MIN > 16) ? LW_MIN : 16;
    localparam logic signed [LW-1:0] MAX_LAST = LW'(MAX_ROW_BITS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_BIT   = 2'd3;

    function automatic logic [REP_W-1:0] clamp_reps(input logic [5:0] v,
                                                    input logic [REP_W-1:0] z);
        logic [REP_W-1:0] r;
        if (v == 6'd0)
        begin
            r = REP_W'(1);
        end
        else if (int'(v) > int'(z))
        begin
            r = z;
        end
        else
        begin
            r = REP_W'(v);
        end
        return r;
    endfunction

    // Column within the matrix of a bit offset below eight.
    function automatic logic [MS_W-1:0] side_mod(input logic [2:0] v);
        logic [3:0] t;
        t = {1'b0, v};
        for (int i = 0; i < 8; i++)
        begin
            if (int'(t) >= MATRIX_SIDE)
            begin
                t = 4'(int'(t) - MATRIX_SIDE);
            end
        end
        return MS_W'(t);
    endfunction

    // Configuration registers.
    logic [5:0]          zoom_reg;
    logic [5:0]          fxr_reg;
    logic [5:0]          fyr_reg;
    logic [11:0]         x_start_reg;
    logic [12:0]         width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [9:0]          line_bytes_reg;
    logic                invert_reg;

    // Sequencer state.
    logic [1:0]         state_reg, state_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [MS_W-1:0]    mrow_reg, mrow_next;
    logic [MS_W-1:0]    mcol_reg, mcol_next;
    logic [POS_W-1:0]   bit_pos_reg, bit_pos_next;
    logic [REP_W-1:0]   x_rep_reg, x_rep_next;
    logic [REP_W-1:0]   y_rep_reg, y_rep_next;
    logic [7:0]         acc_reg, acc_next;
    logic               row_fresh_reg, row_fresh_next;
    logic               region_fresh_reg, region_fresh_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    // Input fields.
    logic               in_action;
    logic [MAT_AW-1:0]  in_entry_index;
    logic [THR_W-1:0]   in_entry_value;
    logic [LEVEL_W-1:0] in_level;

    // Datapath.
    logic [REP_W-1:0]    ze;
    logic [REP_W-1:0]    x_init;
    logic [REP_W-1:0]    y_init;
    logic [REP_W-1:0]    x_inc;
    logic [REP_W-1:0]    y_inc;
    logic [REP_W-1:0]    rem;
    logic [HEIGHT_W-1:0] h_eff;
    logic signed [LW-1:0] last_a;
    logic signed [LW-1:0] line_last;
    logic signed [LW-1:0] row_last;
    logic signed [LW-1:0] pos_s;
    logic signed [LW-1:0] look_s;
    logic                row_empty;
    logic                row_end;
    logic                byte_full;
    logic                more;
    logic                adv;
    logic                row_wrap;
    logic                bit_set;
    logic [7:0]          acc_set;
    logic                do_close;

    logic [MAT_AW-1:0]   mat_raddr;
    logic [THR_W-1:0]    thr;
    logic                mem_we;

    logic                out_load;
    logic                out_free;
    odz_result_t         out_res;
    odz_result_t         res_q;

    assign in_action      = s_tuser;
    assign in_entry_index = s_tdata[7:0];
    assign in_entry_value = s_tdata[16:8];
    assign in_level       = s_tdata[24:17];

    assign s_tready = (state_reg == S_IDLE);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg       <= 6'd1;
            fxr_reg        <= 6'd1;
            fyr_reg        <= 6'd1;
            x_start_reg    <= 12'd0;
            width_reg      <= 13'd1;
            height_reg     <= HEIGHT_W'(1);
            line_bytes_reg <= 10'd1;
            invert_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ZOOM:          zoom_reg       <= cfg_data[5:0];
                REG_FIRST_X_REPS:  fxr_reg        <= cfg_data[5:0];
                REG_FIRST_Y_REPS:  fyr_reg        <= cfg_data[5:0];
                REG_X_START:       x_start_reg    <= cfg_data[11:0];
                REG_REGION_WIDTH:  width_reg      <= cfg_data[12:0];
                REG_REGION_HEIGHT: height_reg     <= cfg_data[HEIGHT_W-1:0];
                REG_LINE_BYTES:    line_bytes_reg <= cfg_data[9:0];
                REG_INVERT:        invert_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Row geometry and repeat counts
    // ------------------------------------------------------------------
    always_comb
    begin
        if (zoom_reg == 6'd0)
        begin
            ze = REP_W'(1);
        end
        else if (int'(zoom_reg) > MAX_ZOOM)
        begin
            ze = REP_W'(MAX_ZOOM);
        end
        else
        begin
            ze = REP_W'(zoom_reg);
        end

        x_init = REP_W'(1) + ze - clamp_reps(fxr_reg, ze);
        y_init = REP_W'(1) + ze - clamp_reps(fyr_reg, ze);
        x_inc  = x_rep_reg + REP_W'(1);
        y_inc  = y_rep_reg + REP_W'(1);
        rem    = ze - x_rep_reg;
        adv    = (y_inc > ze);

        if (height_reg == HEIGHT_W'(0))
        begin
            h_eff = HEIGHT_W'(1);
        end
        else if (int'(height_reg) > ROW_LIMIT)
        begin
            h_eff = HEIGHT_W'(ROW_LIMIT);
        end
        else
        begin
            h_eff = height_reg;
        end
        row_wrap = (({1'b0, out_row_reg} + HEIGHT_W'(1)) >= h_eff);

        // The row's last bit, clipped to the line end and the row limit.
        last_a    = LW'(x_start_reg[2:0]) + LW'(width_reg) - LW'(1);
        line_last = ((LW'(line_bytes_reg) - LW'(x_start_reg[11:3])) << 3) - LW'(1);
        row_last  = last_a;
        if (line_last < row_last)
        begin
            row_last = line_last;
        end
        if (MAX_LAST < row_last)
        begin
            row_last = MAX_LAST;
        end

        pos_s     = LW'(bit_pos_reg);
        look_s    = LW'(bit_pos_reg) + LW'(rem);
        row_empty = (width_reg == 13'd0) || (pos_s > row_last);
        row_end   = (pos_s == row_last);
        byte_full = (bit_pos_reg[2:0] == 3'd7);
        // Another word follows within this sample if a later byte fills
        // or the row ends among the remaining copies.
        more      = (int'(rem) >= 8) || (look_s >= row_last);
    end

    // ------------------------------------------------------------------
    // Shared compare unit
    // ------------------------------------------------------------------
    assign mat_raddr = MAT_AW'(int'(mrow_reg) * MATRIX_SIDE + int'(mcol_reg));

    always_comb
    begin
        if (invert_reg)
        begin
            bit_set = ({1'b0, level_reg} <= thr);
        end
        else
        begin
            bit_set = ({1'b0, level_reg} > thr);
        end
        acc_set = acc_reg | (8'(bit_set) << bit_pos_reg[2:0]);
    end

    odz_thresh_mem u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (in_entry_index),
        .wdata (in_entry_value),
        .raddr (mat_raddr),
        .rdata (thr)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        out_row_next      = out_row_reg;
        mrow_next         = mrow_reg;
        mcol_next         = mcol_reg;
        bit_pos_next      = bit_pos_reg;
        x_rep_next        = x_rep_reg;
        y_rep_next        = y_rep_reg;
        acc_next          = acc_reg;
        row_fresh_next    = row_fresh_reg;
        region_fresh_next = region_fresh_reg;
        level_next        = level_reg;
        mem_we            = 1'b0;
        out_load          = 1'b0;
        out_res           = '0;
        do_close          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_action == ACT_LOAD)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        level_next = in_level;
                        if (region_fresh_reg)
                        begin
                            y_rep_next        = y_init;
                            region_fresh_next = 1'b0;
                        end
                        if (row_fresh_reg)
                        begin
                            bit_pos_next   = POS_W'(x_start_reg[2:0]);
                            mcol_next      = side_mod(x_start_reg[2:0]);
                            x_rep_next     = x_init;
                            acc_next       = 8'd0;
                            row_fresh_next = 1'b0;
                        end
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                if (row_empty)
                begin
                    if (out_free)
                    begin
                        out_load                   = 1'b1;
                        out_res.set_bits           = acc_reg;
                        out_res.row_index          = out_row_reg;
                        out_res.byte_offset        = bit_pos_reg[BOFF_W+2:3];
                        out_res.last_in_row        = 1'b1;
                        out_res.advance_source_row = adv;
                        out_res.last_of_item       = 1'b1;
                        do_close                   = 1'b1;
                        state_next                 = S_IDLE;
                    end
                end
                else
                begin
                    // The matrix entry for this position is read in this state, so no read state is needed.
                    state_next = S_BIT;
                end
            end

            S_READ:
            begin
                state_next = S_BIT;
            end

            S_BIT:
            begin
                if (!((row_end || byte_full) && !out_free))
                begin
                    out_res.set_bits    = acc_set;
                    out_res.row_index   = out_row_reg;
                    out_res.byte_offset = bit_pos_reg[BOFF_W+2:3];
                    if (row_end)
                    begin
                        out_load                   = 1'b1;
                        out_res.last_in_row        = 1'b1;
                        out_res.advance_source_row = adv;
                        out_res.last_of_item       = 1'b1;
                        do_close                   = 1'b1;
                        state_next                 = S_IDLE;
                    end
                    else
                    begin
                        if (byte_full)
                        begin
                            out_load             = 1'b1;
                            out_res.last_of_item = !more;
                            acc_next             = 8'd0;
                        end
                        else
                        begin
                            acc_next = acc_set;
                        end
                        bit_pos_next = bit_pos_reg + POS_W'(1);
                        if (mcol_reg == MS_W'(MATRIX_SIDE - 1))
                        begin
                            mcol_next = '0;
                        end
                        else
                        begin
                            mcol_next = mcol_reg + MS_W'(1);
                        end
                        if (x_inc > ze)
                        begin
                            x_rep_next = REP_W'(1);
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            x_rep_next = x_inc;
                            state_next = S_READ;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_close)
        begin
            y_rep_next     = adv ? REP_W'(1) : y_inc;
            acc_next       = 8'd0;
            row_fresh_next = 1'b1;
            if (row_wrap)
            begin
                out_row_next      = '0;
                mrow_next         = '0;
                region_fresh_next = 1'b1;
            end
            else
            begin
                out_row_next = out_row_reg + ROW_W'(1);
                if (mrow_reg == MS_W'(MATRIX_SIDE - 1))
                begin
                    mrow_next = '0;
                end
                else
                begin
                    mrow_next = mrow_reg + MS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_row_reg      <= '0;
            mrow_reg         <= '0;
            mcol_reg         <= '0;
            bit_pos_reg      <= '0;
            x_rep_reg        <= REP_W'(1);
            y_rep_reg        <= REP_W'(1);
            acc_reg          <= 8'd0;
            row_fresh_reg    <= 1'b1;
            region_fresh_reg <= 1'b1;
        end
        else
        begin
            state_reg        <= state_next;
            out_row_reg      <= out_row_next;
            mrow_reg         <= mrow_next;
            mcol_reg         <= mcol_next;
            bit_pos_reg      <= bit_pos_next;
            x_rep_reg        <= x_rep_next;
            y_rep_reg        <= y_rep_next;
            acc_reg          <= acc_next;
            row_fresh_reg    <= row_fresh_next;
            region_fresh_reg <= region_fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    odz_out_stage u_out
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (out_load),
        .res_in (out_res),
        .ready  (m_tready),
        .valid  (m_tvalid),
        .res    (res_q),
        .free   (out_free)
    );

    assign m_tdata = {3'b000, res_q.byte_offset, res_q.row_index, res_q.set_bits};
    assign m_tlast = res_q.last_in_row;
    assign m_tuser = {res_q.last_of_item, res_q.advance_source_row};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_bit_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIT) |-> (pos_s <= row_last))
        else $error("bit position beyond the end of the row");

    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIT) |-> (x_rep_reg >= REP_W'(1) && x_rep_reg <= ze))
        else $error("copy count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid || m_tready))
        else $error("result word overwritten before it was taken");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && in_action == ACT_SAMPLE) |=> !s_tready)
        else $error("sample word accepted without entering its sequence");

endmodule

FILE: rtl/odz_thresh_mem.sv
// ----------------------------------------------------------------------------
// odz_thresh_mem
// Threshold matrix store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module odz_thresh_mem
    import odz_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [MAT_AW-1:0] waddr,
    input  logic [THR_W-1:0]  wdata,
    input  logic [MAT_AW-1:0] raddr,
    output logic [THR_W-1:0]  rdata
);

    logic [THR_W-1:0] mem [MAT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/odz_out_stage.sv
// ----------------------------------------------------------------------------
// odz_out_stage
// Output register of the result stream; holds a word until it is taken.
// ----------------------------------------------------------------------------
module odz_out_stage
    import odz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  odz_result_t res_in,
    input  logic        ready,
    output logic        valid,
    output odz_result_t res,
    output logic        free
);

    logic        valid_reg;
    odz_result_t res_reg;

    assign free  = !valid_reg || ready;
    assign valid = valid_reg;
    assign res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

FILE: tb/sv/ordered_dither_zoom_replicate_top_test.sv
// ----------------------------------------------------------------------------
// ordered_dither_zoom_replicate_top_test
// Self-checking bench for the ordered-dither zoom replicator. Threshold loads
// and source levels are streamed in while a behavioural predictor works out
// every bitmap byte the block should emit; each result word is checked field
// by field against the oldest prediction, under varying back-pressure.
// ----------------------------------------------------------------------------
module ordered_dither_zoom_replicate_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import odz_pkg::*;

    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // entry_index, entry_value, level, zero pad
    logic                  s_tuser;   // action
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;   // set_bits, row_index, byte_offset, zero pad
    logic                  m_tlast;   // last_in_row
    logic [1:0]            m_tuser;   // advance_source_row, last_of_item

    ordered_dither_zoom_replicate_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Register copies held by the predictor.
    logic [5:0]  zoom_reg;
    logic [5:0]  first_x_reg;
    logic [5:0]  first_y_reg;
    logic [11:0] x_start_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [9:0]  line_bytes_reg;
    logic        invert_reg;

    // Predictor state.
    logic [8:0]  thr_mem [MAT_DEPTH];
    logic [11:0] dither_row;
    int          bit_pos;
    int          x_rep;
    int          y_rep;
    logic [7:0]  acc;
    bit          row_fresh;
    bit          region_fresh;

    odz_result_t item_bytes[$];
    odz_result_t bitmap_bytes_due[$];
    odz_result_t checked_word;

    int error_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_req;

    function automatic int clamp_reps(int v, int ze);
        if (v < 1)
            return 1;
        if (v > ze)
            return ze;
        return v;
    endfunction

    // Last bit position of the current row, or a negative value when the row holds no bits.
    function automatic int row_last_bit();
        int b0;
        int xb;
        int last;
        int line_last;
        b0 = x_start_reg[2:0];
        xb = x_start_reg[11:3];
        last = b0 + int'(width_reg) - 1;
        line_last = (int'(line_bytes_reg) - xb) * 8 - 1;
        if (width_reg == 0)
            return -1;
        if (last > line_last)
            last = line_last;
        if (last > DEF_MAX_ROW_BITS - 1)
            last = DEF_MAX_ROW_BITS - 1;
        return last;
    endfunction

    function automatic void queue_byte(logic [7:0] bits, int pos, logic row_end, logic adv);
        odz_result_t w;
        w.set_bits           = bits;
        w.row_index          = dither_row;
        w.byte_offset        = BOFF_W'(pos >> 3);
        w.last_in_row        = row_end;
        w.advance_source_row = adv;
        w.last_of_item       = 1'b0;
        item_bytes.push_back(w);
    endfunction

    function automatic void end_row(int ze);
        int   h;
        logic adv;
        adv = 1'b0;
        y_rep++;
        if (y_rep > ze)
        begin
            y_rep = 1;
            adv = 1'b1;
        end
        h = height_reg;
        if (h < 1)
            h = 1;
        if (h > ROW_LIMIT)
            h = ROW_LIMIT;
        queue_byte(acc, bit_pos, 1'b1, adv);
        acc = '0;
        if (int'(dither_row) + 1 >= h)
        begin
            dither_row = '0;
            region_fresh = 1'b1;
        end
        else
            dither_row++;
        row_fresh = 1'b1;
    endfunction

    // Replicates one source level along the row and queues the bytes it completes.
    function automatic void predict_sample(logic [7:0] level);
        int          ze;
        int          last;
        int          thr_idx;
        bit          set;
        odz_result_t final_word;
        item_bytes.delete();
        ze = zoom_reg;
        if (ze < 1)
            ze = 1;
        if (ze > DEF_MAX_ZOOM)
            ze = DEF_MAX_ZOOM;
        if (region_fresh)
        begin
            y_rep = 1 + ze - clamp_reps(first_y_reg, ze);
            region_fresh = 1'b0;
        end
        if (row_fresh)
        begin
            bit_pos = x_start_reg[2:0];
            x_rep = 1 + ze - clamp_reps(first_x_reg, ze);
            acc = '0;
            row_fresh = 1'b0;
        end
        last = row_last_bit();
        if (last < 0 || bit_pos > last)
            end_row(ze);
        else
        begin
            forever
            begin
                thr_idx = (int'(dither_row) % DEF_MATRIX_SIDE) * DEF_MATRIX_SIDE
                          + bit_pos % DEF_MATRIX_SIDE;
                set = invert_reg ? (level <= thr_mem[thr_idx]) : (level > thr_mem[thr_idx]);
                if (set)
                    acc[bit_pos % 8] = 1'b1;
                if (bit_pos == last)
                begin
                    end_row(ze);
                    break;
                end
                if (bit_pos % 8 == 7)
                begin
                    queue_byte(acc, bit_pos, 1'b0, 1'b0);
                    acc = '0;
                end
                bit_pos = (bit_pos + 1) & 'h1FFF;
                x_rep++;
                if (x_rep > ze)
                begin
                    x_rep = 1;
                    break;
                end
            end
        end
        if (item_bytes.size() > 0)
        begin
            final_word = item_bytes.pop_back();
            final_word.last_of_item = 1'b1;
            item_bytes.push_back(final_word);
        end
        foreach (item_bytes[i])
            bitmap_bytes_due.push_back(item_bytes[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (bitmap_bytes_due.size() == 0)
            begin
                $error("result word with nothing expected: tdata %h", m_tdata);
                error_count++;
            end
            else
            begin
                checked_word = bitmap_bytes_due.pop_front();
                check_field("set_bits", checked_word.set_bits, m_tdata[7:0]);
                check_field("row_index", checked_word.row_index, m_tdata[19:8]);
                check_field("byte_offset", checked_word.byte_offset, m_tdata[28:20]);
                check_field("last_in_row", checked_word.last_in_row, m_tlast);
                check_field("advance_source_row", checked_word.advance_source_row, m_tuser[0]);
                check_field("last_of_item", checked_word.last_of_item, m_tuser[1]);
            end
        end
    end

    // Receiver: random stalls, or one long hold-off when asked for.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ordered_dither_zoom_replicate_top test failed");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [7:0] idx, input logic [8:0] val,
                             input logic [7:0] lvl);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'b0, lvl, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (act == ACT_LOAD)
            thr_mem[idx] = val;
        else
            predict_sample(lvl);
    endtask

    task automatic send_level(input logic [7:0] lvl);
        send_word(ACT_SAMPLE, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)), lvl);
    endtask

    task automatic send_random_item();
        logic [7:0] lvl;
        case ($urandom_range(0, 7))
            0:       lvl = 8'h00;
            1:       lvl = 8'hFF;
            default: lvl = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 9) == 0)
            send_word(ACT_LOAD, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 256)), lvl);
        else
            send_level(lvl);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ZOOM:          zoom_reg       = value[5:0];
            REG_FIRST_X_REPS:  first_x_reg    = value[5:0];
            REG_FIRST_Y_REPS:  first_y_reg    = value[5:0];
            REG_X_START:       x_start_reg    = value[11:0];
            REG_REGION_WIDTH:  width_reg      = value[12:0];
            REG_REGION_HEIGHT: height_reg     = value[12:0];
            REG_LINE_BYTES:    line_bytes_reg = value[9:0];
            REG_INVERT:        invert_reg     = value[0];
            default:           ;
        endcase
    endtask

    task automatic configure(input int z, input int fx, input int fy, input int xs,
                             input int w, input int h, input int lb, input int inv);
        write_reg(REG_ZOOM, z);
        write_reg(REG_FIRST_X_REPS, fx);
        write_reg(REG_FIRST_Y_REPS, fy);
        write_reg(REG_X_START, xs);
        write_reg(REG_REGION_WIDTH, w);
        write_reg(REG_REGION_HEIGHT, h);
        write_reg(REG_LINE_BYTES, lb);
        write_reg(REG_INVERT, inv);
    endtask

    // Samples that end inside a byte give no word, so let the block finish them too.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (bitmap_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Every entry is written before any sample can read it.
    task automatic test_matrix_load();
        for (int i = 0; i < MAT_DEPTH; i++)
        begin
            if (i == 0)
                send_word(ACT_LOAD, 8'(i), 9'd0, 8'($urandom_range(0, 255)));
            else if (i == 1)
                send_word(ACT_LOAD, 8'(i), 9'd256, 8'($urandom_range(0, 255)));
            else
                send_word(ACT_LOAD, 8'(i), 9'($urandom_range(0, 256)),
                          8'($urandom_range(0, 255)));
        end
        wait_idle();
    endtask

    task automatic test_level_extremes();
        configure(4, 4, 1, 0, 16, 2, 2, 0);
        send_level(8'h00);
        send_level(8'hFF);
        send_level(8'h55);
        send_level(8'hAA);
        wait_idle();
        write_reg(REG_INVERT, 1);
        send_level(8'h00);
        send_level(8'hFF);
        send_level(8'h55);
        send_level(8'hAA);
        wait_idle();
    endtask

    task automatic test_empty_rows();
        configure(2, 1, 1, 0, 0, 3, 4, 0);
        send_level(8'h80);
        send_level(8'h01);
        wait_idle();
        write_reg(REG_REGION_WIDTH, 8);
        write_reg(REG_LINE_BYTES, 0);
        send_level(8'hFF);
        wait_idle();
        // Region starts beyond the end of the line.
        write_reg(REG_X_START, 40);
        write_reg(REG_LINE_BYTES, 4);
        send_level(8'h7F);
        wait_idle();
    endtask

    task automatic test_register_clamping();
        configure(0, 0, 0, 5, 3, 0, 2, 0);
        send_level(8'hC3);
        send_level(8'h3C);
        send_level(8'hFF);
        wait_idle();
        // The second sample reaches the row end part way and loses its remaining copies.
        configure(63, 50, 40, 3, 40, 8191, 10, 1);
        send_level(8'h40);
        send_level(8'hB0);
        send_level(8'h10);
        wait_idle();
    endtask

    task automatic test_mid_row_shrink();
        configure(8, 5, 1, 0, 64, 4, 8, 0);
        send_level(8'hFE);
        send_level(8'h81);
        send_level(8'hFF);
        wait_idle();
        // The row end now lies behind the current position, so the pending bits go at once.
        write_reg(REG_REGION_WIDTH, 10);
        send_level(8'h20);
        send_level(8'hE0);
        wait_idle();
    endtask

    task automatic test_random_config(input int n_items);
        int z;
        int xs;
        int lb;
        z  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8);
        xs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 63);
        lb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                         : (xs >> 3) + $urandom_range(1, 12);
        configure(z,
                  (z + 2 > 63) ? $urandom_range(0, 63) : $urandom_range(0, z + 2),
                  (z + 2 > 63) ? $urandom_range(0, 63) : $urandom_range(0, z + 2),
                  xs,
                  ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 80),
                  ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 6),
                  lb,
                  $urandom_range(0, 1));
        repeat (n_items) send_random_item();
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        configure(8, 8, 1, 0, 64, 4, 8, 0);
        hold_off_req = 1'b1;
        repeat (24) send_level(8'($urandom_range(0, 255)));
        wait_idle();
    endtask

    // A row clipped at the line end, with the widest replication.
    task automatic test_full_width_row();
        configure(63, 32, 1, 7, 8191, 1, 40, $urandom_range(0, 1));
        repeat (12) send_random_item();
        wait_idle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_LOAD;
        zoom_reg       = 6'd1;
        first_x_reg    = 6'd1;
        first_y_reg    = 6'd1;
        x_start_reg    = '0;
        width_reg      = 13'd1;
        height_reg     = 13'd1;
        line_bytes_reg = 10'd1;
        invert_reg     = 1'b0;
        dither_row     = '0;
        bit_pos        = 0;
        x_rep          = 1;
        y_rep          = 1;
        acc            = '0;
        row_fresh      = 1'b1;
        region_fresh   = 1'b1;
        error_count    = 0;
        cycle_count    = 0;
        hold_off_req   = 1'b0;
        send_idle_pct  = 15;
        recv_idle_pct  = 58;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_matrix_load();
        test_level_extremes();
        test_empty_rows();
        test_register_clamping();
        test_mid_row_shrink();
        repeat (3) test_random_config(5);
        test_output_backpressure();

        send_idle_pct = 58;
        recv_idle_pct = 15;
        repeat (3) test_random_config(5);
        test_full_width_row();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) test_random_config(5);

        if (error_count == 0)
            $display("ordered_dither_zoom_replicate_top test passed");
        else
            $display("ordered_dither_zoom_replicate_top test failed");
        $finish;
    end

endmodule
